// ----- sv/dcbd_pkg.sv -----
// Shared types, constants and offset table for the dense-code bitstream decoder.
package dcbd_pkg;

    localparam int unsigned INDEX_W   = 22;
    localparam int unsigned RUN_W     = 23;
    localparam int unsigned IDX_SUM_W = 27;

    localparam logic [3:0]         NUM_STOPPERS  = 4'd7;
    localparam logic [2:0]         MAX_RUN       = 3'd7;
    localparam logic [RUN_W-1:0]   RUN_MAX_VALUE = 23'h7F_FFFF;
    localparam logic [INDEX_W-1:0] DICT_RESET    = 22'd262144;

    localparam logic [1:0] ST_WORD      = 2'd0;
    localparam logic [1:0] ST_END_CLEAN = 2'd1;
    localparam logic [1:0] ST_END_DROP  = 2'd2;
    localparam logic [1:0] ST_INDEX_ERR = 2'd3;

    typedef struct packed {
        logic code_bit;
        logic final_bit;
    } in_word_t;

    typedef struct packed {
        logic [INDEX_W-1:0] word_index;
        logic               add_space;
        logic [1:0]         status;
        logic               end_of_message;
    } out_word_t;

    // First index of the codewords with k continuers: 7*(9^k-1)/8
    function automatic logic [INDEX_W-1:0] run_offset(input logic [2:0] k);
        logic [INDEX_W-1:0] r;
        case (k)
            3'd0: r = 22'd0;
            3'd1: r = 22'd7;
            3'd2: r = 22'd70;
            3'd3: r = 22'd637;
            3'd4: r = 22'd5740;
            3'd5: r = 22'd51667;
            3'd6: r = 22'd465010;
            3'd7: r = 22'd4185097;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/dense_code_bitstream_decoder.sv -----
// Top level of the dense-code bitstream decoder: bit parser, state and result queue.
//
// Usage:
//   s_valid/s_ready/s_data carry one message bit per word (code_bit, and final_bit
//   on the last bit of a message). m_valid/m_ready/m_data carry results: a decoded
//   dictionary index with its add_space flag, an index error, or the end result
//   that closes a message.
//   cfg_wr_en/cfg_wr_data write the dictionary size; write it only while idle.
// A result caused by a bit enters the result queue when that bit is taken.
// Throughput: one bit per cycle while s_ready is high. A bit causes at most two
//   results; they go into a four-entry result queue and leave at one per cycle while
//   m_ready is high. s_ready is high while the queue has room for two, so a stalled
//   receiver backs up into s_ready after the queue fills, and no result is ever lost.
// Reset (aresetn low, synchronous): parser state and queue are cleared and the
//   dictionary size returns to 262144.
// After the last bit of a message the parser starts over with the next bit.
module dense_code_bitstream_decoder (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  dcbd_pkg::in_word_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output dcbd_pkg::out_word_t               m_data,
    input  logic                              cfg_wr_en,
    input  logic [dcbd_pkg::INDEX_W-1:0]      cfg_wr_data
);

    logic [dcbd_pkg::INDEX_W-1:0] dict_size_reg;

    logic [2:0]                   nibble_reg, nibble_next;
    logic [1:0]                   bit_count_reg, bit_count_next;
    logic                         await_sep_reg, await_sep_next;
    logic [2:0]                   run_len_reg, run_len_next;
    logic [dcbd_pkg::RUN_W-1:0]   run_val_reg, run_val_next;
    logic [dcbd_pkg::INDEX_W-1:0] held_idx_reg, held_idx_next;
    logic                         halted_reg, halted_next;

    dcbd_pkg::out_word_t          res0, res1;
    logic [1:0]                   n_res;

    dcbd_pkg::out_word_t          queue_reg [4];
    logic [1:0]                   wr_ptr_reg, rd_ptr_reg;
    logic [2:0]                   count_reg;

    logic                         accept, pop;
    logic [3:0]                   nib_full;
    logic [25:0]                  run_x7, run_x9;
    logic [dcbd_pkg::IDX_SUM_W-1:0] idx_sum, cont_sum;
    logic                         last;

    assign accept  = s_valid && s_ready;
    assign pop     = m_valid && m_ready;
    assign s_ready = (count_reg <= 3'd2);
    assign m_valid = (count_reg != 3'd0);
    assign m_data  = queue_reg[rd_ptr_reg];
    assign last    = s_data.final_bit;

    assign nib_full = {nibble_reg, s_data.code_bit};
    assign run_x7   = {run_val_reg, 3'b000} - {3'b000, run_val_reg};
    assign run_x9   = {run_val_reg, 3'b000} + {3'b000, run_val_reg};
    assign idx_sum  = {1'b0, run_x7} + {23'd0, nib_full}
                    + {5'd0, dcbd_pkg::run_offset(run_len_reg)};
    assign cont_sum = {1'b0, run_x9} + {23'd0, nib_full - dcbd_pkg::NUM_STOPPERS};

    always_comb begin
        nibble_next    = nibble_reg;
        bit_count_next = bit_count_reg;
        await_sep_next = await_sep_reg;
        run_len_next   = run_len_reg;
        run_val_next   = run_val_reg;
        held_idx_next  = held_idx_reg;
        halted_next    = halted_reg;
        res0           = '0;
        res1           = '0;
        n_res          = 2'd0;

        if (halted_reg) begin
            if (last) begin
                res0.status         = dcbd_pkg::ST_END_DROP;
                res0.end_of_message = 1'b1;
                n_res               = 2'd1;
            end
        end else begin
            if (await_sep_reg) begin
                res0.word_index = held_idx_reg;
                res0.add_space  = s_data.code_bit;
                res0.status     = dcbd_pkg::ST_WORD;
                n_res           = 2'd1;
                await_sep_next  = 1'b0;
                held_idx_next   = '0;
            end else if (bit_count_reg == 2'd3) begin
                nibble_next    = '0;
                bit_count_next = '0;
                if (nib_full >= dcbd_pkg::NUM_STOPPERS) begin
                    if (run_len_reg >= dcbd_pkg::MAX_RUN) begin
                        res0.status = dcbd_pkg::ST_INDEX_ERR;
                        n_res       = 2'd1;
                        halted_next = 1'b1;
                    end else begin
                        run_val_next = (cont_sum > {4'd0, dcbd_pkg::RUN_MAX_VALUE})
                                     ? dcbd_pkg::RUN_MAX_VALUE
                                     : cont_sum[dcbd_pkg::RUN_W-1:0];
                        run_len_next = run_len_reg + 3'd1;
                    end
                end else begin
                    run_len_next = '0;
                    run_val_next = '0;
                    if (idx_sum >= {5'd0, dict_size_reg}) begin
                        res0.status = dcbd_pkg::ST_INDEX_ERR;
                        n_res       = 2'd1;
                        halted_next = 1'b1;
                    end else begin
                        held_idx_next  = idx_sum[dcbd_pkg::INDEX_W-1:0];
                        await_sep_next = 1'b1;
                    end
                end
            end else begin
                nibble_next    = nib_full[2:0];
                bit_count_next = bit_count_reg + 2'd1;
            end

            if (last) begin
                // n_res is 1 after a separator or error; 0 otherwise, as after a stopper
                if (await_sep_next) begin
                    res0.word_index     = held_idx_next;
                    res0.add_space      = 1'b0;
                    res0.status         = dcbd_pkg::ST_WORD;
                    res1.status         = dcbd_pkg::ST_END_CLEAN;
                    res1.end_of_message = 1'b1;
                    n_res               = 2'd2;
                end else if (n_res == 2'd1) begin
                    res1.status         = (halted_next || bit_count_next != 2'd0 ||
                                           run_len_next != 3'd0)
                                        ? dcbd_pkg::ST_END_DROP : dcbd_pkg::ST_END_CLEAN;
                    res1.end_of_message = 1'b1;
                    n_res               = 2'd2;
                end else begin
                    res0.status         = (bit_count_next != 2'd0 || run_len_next != 3'd0)
                                        ? dcbd_pkg::ST_END_DROP : dcbd_pkg::ST_END_CLEAN;
                    res0.end_of_message = 1'b1;
                    n_res               = 2'd1;
                end
            end
        end

        if (last) begin
            nibble_next    = '0;
            bit_count_next = '0;
            await_sep_next = 1'b0;
            run_len_next   = '0;
            run_val_next   = '0;
            held_idx_next  = '0;
            halted_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dict_size_reg <= dcbd_pkg::DICT_RESET;
        end else if (cfg_wr_en) begin
            dict_size_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nibble_reg    <= '0;
            bit_count_reg <= '0;
            await_sep_reg <= 1'b0;
            run_len_reg   <= '0;
            run_val_reg   <= '0;
            held_idx_reg  <= '0;
            halted_reg    <= 1'b0;
        end else if (accept) begin
            nibble_reg    <= nibble_next;
            bit_count_reg <= bit_count_next;
            await_sep_reg <= await_sep_next;
            run_len_reg   <= run_len_next;
            run_val_reg   <= run_val_next;
            held_idx_reg  <= held_idx_next;
            halted_reg    <= halted_next;
        end
    end

    // result queue: up to two pushes and one pop per cycle
    always_ff @(posedge aclk) begin
        if (accept && n_res != 2'd0) begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (accept && n_res == 2'd2) begin
            queue_reg[wr_ptr_reg + 2'd1] <= res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (accept) begin
                wr_ptr_reg <= wr_ptr_reg + n_res;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + (accept ? {1'b0, n_res} : 3'd0)
                       - (pop ? 3'd1 : 3'd0);
        end
    end

endmodule
